FILE: rtl/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg: shared constants for the run-length symbol store
// Widths of symbols, positions, run bytes and the run store depth, with limits and the operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rle_pkg;

    localparam int RUN_SLOTS = 256;
    localparam int IDX_W     = $clog2(RUN_SLOTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int POS_W     = 13;
    localparam int SYM_W     = 3;
    localparam int LEN_W     = 5;
    localparam int BYTE_W    = LEN_W + SYM_W;
    localparam int LIMIT_W   = 9;

    localparam logic [LEN_W-1:0]   MAX_LEN     = 5'd31;
    localparam logic [POS_W-1:0]   LEN_CAP     = 13'd8191;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd64;
    localparam logic [SYM_W-1:0]   SYM_LAST    = 3'd5;

    typedef enum logic [1:0]
    {
        OP_RANK   = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/rle_run_ram.sv
// ----------------------------------------------------------------------------
// rle_run_ram: run byte store
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_run_ram
#(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/rle_symbol_run_rank_insert.sv
// Rank scans the runs up to the position. Insert also moves runs up when a new
// run needs a slot, plus a forward scan over equal-symbol runs. Read fetches
// one run byte. One item at a time: the run store port sets the pace.
// Reset clears run count, string length and the run_limit register (to 64);
// the run store itself needs no clearing.
// ----------------------------------------------------------------------------
// rle_symbol_run_rank_insert: run-length symbol string with rank and insert
// Sequencer over a run store with one write and one read port that scans, shifts and patches runs.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_symbol_run_rank_insert
    import rle_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wen,
    input  wire logic [LIMIT_W-1:0]  cfg_wdata,   // run_limit
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [15:0]         s_tdata,     // symbol[2:0], position[15:3]
    input  wire logic [1:0]          s_tuser,     // operation[1:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // rank[12:0], run_index[20:13], run_offset[25:21], run_total[34:26],
    // run_byte[42:35], needs_split[43], status[45:44], zero[47:46]
    output logic [47:0]              m_tdata
);

    typedef enum logic [4:0]
    {
        S_IDLE, S_LOC_RD, S_LOC_EV, S_NXT_RD, S_NXT_EV, S_DECIDE,
        S_F_CHK, S_F_EV, S_C4_FIN, S_C6_SCAN, S_C6_FIN, S_C7B, S_C7C,
        S_P_START, S_SH_RD, S_SH_WR, S_P_WR, S_RD_RD, S_RD_EV, S_DONE
    } state_t;

    state_t state_reg, ret_reg;

    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [POS_W-1:0]   total_reg;

    logic [SYM_W-1:0]   sym_reg;
    logic [POS_W-1:0]   x_reg;

    logic [POS_W-1:0]   rk_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   off_reg;
    logic [BYTE_W-1:0]  byte_reg;
    status_t            status_reg;

    logic [IDX_W-1:0]   k_reg;
    logic [POS_W-1:0]   cum_reg;
    logic               ins_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [BYTE_W-1:0]  bi_reg;
    logic [BYTE_W-1:0]  nb_reg;
    logic               nok_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [BYTE_W-1:0]  bj_reg;
    logic [SYM_W-1:0]   fsym_reg;
    logic [LEN_W-1:0]   rest_reg;
    logic [SYM_W-1:0]   c_reg;
    logic [IDX_W-1:0]   p_reg;
    logic [BYTE_W-1:0]  pb_reg;
    logic [IDX_W-1:0]   m_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    rle_run_ram
    #(
        .DEPTH (RUN_SLOTS),
        .WIDTH (BYTE_W)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // input decode
    op_t              in_op;
    logic [SYM_W-1:0] in_sym;
    logic [POS_W-1:0] in_x;
    logic             in_full;

    assign in_op   = op_t'(s_tuser);
    assign in_sym  = s_tdata[2:0];
    assign in_x    = s_tdata[15:3];
    assign in_full = ((CNT_W+1)'(count_reg) + (CNT_W+1)'(2) > (CNT_W+1)'(RUN_SLOTS))
                     || (total_reg >= LEN_CAP);

    // locate step
    logic [LEN_W-1:0] rd_len;
    logic             rd_match;
    logic [POS_W:0]   loc_sum;
    logic             loc_found;
    logic [LEN_W-1:0] loc_off;

    assign rd_len    = ram_rdata[BYTE_W-1:SYM_W];
    assign rd_match  = (ram_rdata[SYM_W-1:0] == sym_reg);
    assign loc_sum   = {1'b0, cum_reg} + (POS_W+1)'(rd_len);
    assign loc_found = (loc_sum >= {1'b0, x_reg});
    assign loc_off   = LEN_W'(x_reg - cum_reg);

    // insert decisions
    logic [BYTE_W-1:0] one_byte;
    logic [LEN_W-1:0]  rest;
    logic              adv;
    logic [IDX_W-1:0]  ei;
    logic [BYTE_W-1:0] eb;
    logic [BYTE_W-1:0] bi_cut;
    logic              j_next_ok;
    logic [LEN_W:0]    c6_sum;
    logic              k_last;

    assign one_byte  = {LEN_W'(1), sym_reg};
    assign rest      = bi_reg[BYTE_W-1:SYM_W] - off_reg;
    assign adv       = (rest == '0) && nok_reg && (nb_reg[SYM_W-1:0] == sym_reg);
    assign ei        = adv ? i_reg + IDX_W'(1) : i_reg;
    assign eb        = adv ? nb_reg : bi_reg;
    assign bi_cut    = bi_reg - {rest_reg, SYM_W'(0)};
    assign j_next_ok = (CNT_W'(j_reg) + CNT_W'(1)) < count_reg;
    assign c6_sum    = (LEN_W+1)'(bj_reg[BYTE_W-1:SYM_W]) + (LEN_W+1)'(rest_reg);
    assign k_last    = (m_reg == p_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        unique case (state_reg)
            S_LOC_RD: ram_raddr = k_reg;
            S_NXT_RD: ram_raddr = i_reg + IDX_W'(1);
            S_F_CHK:  ram_raddr = j_reg + IDX_W'(1);
            S_SH_RD:  ram_raddr = m_reg;
            S_RD_RD:  ram_raddr = IDX_W'(x_reg);
            S_DECIDE:
            begin
                if (!(off_reg == '0 && bi_reg[SYM_W-1:0] != sym_reg))
                begin
                    if (eb[SYM_W-1:0] == sym_reg)
                    begin
                        ram_we    = (eb[BYTE_W-1:SYM_W] != MAX_LEN);
                        ram_waddr = ei;
                        ram_wdata = eb + BYTE_W'(8);
                    end
                    else if (rest != '0 && nok_reg && nb_reg[SYM_W-1:0] == bi_reg[SYM_W-1:0])
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = i_reg;
                        ram_wdata = bi_reg - {rest, SYM_W'(0)};
                    end
                end
            end
            S_C4_FIN:
            begin
                ram_we    = (bj_reg[BYTE_W-1:SYM_W] != MAX_LEN);
                ram_waddr = j_reg;
                ram_wdata = bj_reg + BYTE_W'(8);
            end
            S_C6_FIN:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = (c6_sum > (LEN_W+1)'(MAX_LEN)) ? {MAX_LEN, c_reg}
                                                           : bj_reg + {rest_reg, SYM_W'(0)};
            end
            S_C7C:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = bi_cut;
            end
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = m_reg + IDX_W'(1);
                ram_wdata = ram_rdata;
            end
            S_P_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = p_reg;
                ram_wdata = pb_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            limit_reg <= LIMIT_RESET;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                limit_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        sym_reg    <= in_sym;
                        x_reg      <= in_x;
                        rk_reg     <= '0;
                        idx_reg    <= '0;
                        off_reg    <= '0;
                        byte_reg   <= '0;
                        status_reg <= ST_OK;
                        k_reg      <= '0;
                        cum_reg    <= '0;
                        ins_reg    <= (in_op == OP_INSERT) && !in_full;
                        priority if (in_op == OP_NONE)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (in_op == OP_READ)
                        begin
                            if ((CNT_W+POS_W)'(in_x) < (CNT_W+POS_W)'(count_reg))
                            begin
                                state_reg <= S_RD_RD;
                            end
                            else
                            begin
                                status_reg <= ST_BAD;
                                state_reg  <= S_DONE;
                            end
                        end
                        else if (in_x > total_reg || (in_op == OP_INSERT && in_sym > SYM_LAST))
                        begin
                            status_reg <= ST_BAD;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            if (in_op == OP_INSERT && in_full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            if (in_op == OP_INSERT && !in_full)
                            begin
                                total_reg <= total_reg + POS_W'(1);
                            end
                            if (count_reg == '0)
                            begin
                                // empty store: first run goes to slot zero
                                p_reg     <= '0;
                                pb_reg    <= {LEN_W'(1), in_sym};
                                ret_reg   <= S_DONE;
                                state_reg <= (in_op == OP_INSERT) ? S_P_START : S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_LOC_RD;
                            end
                        end
                    end
                end
                S_LOC_RD: state_reg <= S_LOC_EV;
                S_LOC_EV:
                begin
                    if (loc_found)
                    begin
                        idx_reg <= k_reg;
                        off_reg <= loc_off;
                        rk_reg  <= rk_reg + (rd_match ? POS_W'(loc_off) : '0);
                        i_reg   <= k_reg;
                        bi_reg  <= ram_rdata;
                        nok_reg <= 1'b0;
                        if (!ins_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if ((CNT_W'(k_reg) + CNT_W'(1)) < count_reg)
                        begin
                            state_reg <= S_NXT_RD;
                        end
                        else
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                    else
                    begin
                        rk_reg    <= rk_reg + (rd_match ? POS_W'(rd_len) : '0);
                        cum_reg   <= POS_W'(loc_sum);
                        k_reg     <= k_reg + IDX_W'(1);
                        state_reg <= S_LOC_RD;
                    end
                end
                S_NXT_RD: state_reg <= S_NXT_EV;
                S_NXT_EV:
                begin
                    nb_reg    <= ram_rdata;
                    nok_reg   <= 1'b1;
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    rest_reg <= rest;
                    c_reg    <= bi_reg[SYM_W-1:0];
                    priority if (off_reg == '0 && bi_reg[SYM_W-1:0] != sym_reg)
                    begin
                        // new run ahead of run zero
                        p_reg     <= '0;
                        pb_reg    <= one_byte;
                        ret_reg   <= S_DONE;
                        state_reg <= S_P_START;
                    end
                    else if (eb[SYM_W-1:0] == sym_reg)
                    begin
                        if (eb[BYTE_W-1:SYM_W] != MAX_LEN)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            j_reg     <= ei;
                            bj_reg    <= eb;
                            fsym_reg  <= sym_reg;
                            ret_reg   <= S_C4_FIN;
                            state_reg <= S_F_CHK;
                        end
                    end
                    else if (rest == '0)
                    begin
                        p_reg     <= i_reg + IDX_W'(1);
                        pb_reg    <= one_byte;
                        ret_reg   <= S_DONE;
                        state_reg <= S_P_START;
                    end
                    else if (nok_reg && nb_reg[SYM_W-1:0] == bi_reg[SYM_W-1:0])
                    begin
                        p_reg     <= i_reg + IDX_W'(1);
                        pb_reg    <= one_byte;
                        ret_reg   <= S_C6_SCAN;
                        state_reg <= S_P_START;
                    end
                    else
                    begin
                        // split: tail of the run first, then the new symbol
                        p_reg     <= i_reg + IDX_W'(1);
                        pb_reg    <= {rest, bi_reg[SYM_W-1:0]};
                        ret_reg   <= S_C7B;
                        state_reg <= S_P_START;
                    end
                end
                S_F_CHK:
                begin
                    state_reg <= j_next_ok ? S_F_EV : ret_reg;
                end
                S_F_EV:
                begin
                    if (ram_rdata[SYM_W-1:0] == fsym_reg)
                    begin
                        j_reg     <= j_reg + IDX_W'(1);
                        bj_reg    <= ram_rdata;
                        state_reg <= S_F_CHK;
                    end
                    else
                    begin
                        state_reg <= ret_reg;
                    end
                end
                S_C4_FIN:
                begin
                    if (bj_reg[BYTE_W-1:SYM_W] == MAX_LEN)
                    begin
                        p_reg     <= j_reg + IDX_W'(1);
                        pb_reg    <= one_byte;
                        ret_reg   <= S_DONE;
                        state_reg <= S_P_START;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_C6_SCAN:
                begin
                    j_reg     <= i_reg + IDX_W'(2);
                    bj_reg    <= nb_reg;
                    fsym_reg  <= c_reg;
                    ret_reg   <= S_C6_FIN;
                    state_reg <= S_F_CHK;
                end
                S_C6_FIN:
                begin
                    if (c6_sum > (LEN_W+1)'(MAX_LEN))
                    begin
                        p_reg     <= j_reg + IDX_W'(1);
                        pb_reg    <= {LEN_W'(c6_sum - (LEN_W+1)'(MAX_LEN)), c_reg};
                        ret_reg   <= S_DONE;
                        state_reg <= S_P_START;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_C7B:
                begin
                    p_reg     <= i_reg + IDX_W'(1);
                    pb_reg    <= one_byte;
                    ret_reg   <= S_C7C;
                    state_reg <= S_P_START;
                end
                S_C7C: state_reg <= S_DONE;
                S_P_START:
                begin
                    m_reg     <= IDX_W'(count_reg - CNT_W'(1));
                    state_reg <= (count_reg == CNT_W'(p_reg)) ? S_P_WR : S_SH_RD;
                end
                S_SH_RD: state_reg <= S_SH_WR;
                S_SH_WR:
                begin
                    if (k_last)
                    begin
                        state_reg <= S_P_WR;
                    end
                    else
                    begin
                        m_reg     <= m_reg - IDX_W'(1);
                        state_reg <= S_SH_RD;
                    end
                end
                S_P_WR:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ret_reg;
                end
                S_RD_RD: state_reg <= S_RD_EV;
                S_RD_EV:
                begin
                    idx_reg   <= IDX_W'(x_reg);
                    byte_reg  <= ram_rdata;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic split_flag;
    assign split_flag = ((LIMIT_W+1)'(count_reg) + (LIMIT_W+1)'(2)) > (LIMIT_W+1)'(limit_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_DONE);
    assign m_tdata  = {2'b00, status_reg, split_flag, byte_reg, 9'(count_reg),
                       off_reg, 8'(idx_reg), rk_reg};

    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input and output sides open together");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RUN_SLOTS))
        else $error("run count beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg != S_IDLE && state_reg != S_DONE)
        else $error("run store written outside an insert");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_P_WR |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("run count did not advance on put");

endmodule

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the run-length symbol store
// Drives rank, insert, read and no-op items over the input stream, predicts every
// result with a local model of the run store, and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import rle_pkg::*;
();

    localparam int LIMIT_CYCLES = 3000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [8:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    rle_symbol_run_rank_insert dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    typedef struct packed
    {
        logic [1:0]  status;
        logic        needs_split;
        logic [7:0]  run_byte;
        logic [8:0]  run_total;
        logic [4:0]  run_offset;
        logic [7:0]  run_index;
        logic [12:0] rank;
    } answer_t;

    typedef struct
    {
        op_t        op;
        logic [2:0] sym;
        int         pos;
        logic       fixed;
        answer_t    ans;
    } row_t;

    // store model
    logic [7:0] runs [RUN_SLOTS];
    int         nruns;
    int         sym_count [6];
    int         limit_reg;

    answer_t    pending [$];
    int         errors;
    int         cycles;
    bit         quiet;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int str_len();
        int t;
        t = 0;
        for (int k = 0; k < 6; k++)
            t += sym_count[k];
        return t;
    endfunction

    function automatic int rlen(int k);
        return int'(runs[k][7:3]);
    endfunction

    function automatic int rsym(int k);
        return int'(runs[k][2:0]);
    endfunction

    function automatic void open_gap(int at, int n);
        for (int k = nruns - 1; k >= at; k--)
            runs[k + n] = runs[k];
        nruns += n;
    endfunction

    function automatic int find_run(int x, int s, output int idx, output int off);
        int cum, rk, len;
        cum = 0;
        rk = 0;
        idx = 0;
        off = 0;
        if (x == 0 || nruns == 0)
            return 0;
        for (int k = 0; k < nruns; k++)
        begin
            len = rlen(k);
            if (cum + len >= x)
            begin
                idx = k;
                off = x - cum;
                if (rsym(k) == s)
                    rk += x - cum;
                return rk;
            end
            if (rsym(k) == s)
                rk += len;
            cum += len;
        end
        return rk;
    endfunction

    function automatic void add_one(int a, int i, int off);
        int rest, j, c, spill;
        logic [7:0] one;
        one = {5'd1, 3'(a)};
        if (nruns == 0)
        begin
            runs[0] = one;
            nruns = 1;
            return;
        end
        rest = rlen(i) - off;
        if (off == 0 && rsym(i) != a)
        begin
            open_gap(0, 1);
            runs[0] = one;
            return;
        end
        if (rest == 0 && i + 1 < nruns && rsym(i + 1) == a)
            i++;
        if (rsym(i) == a)
        begin
            if (rlen(i) == 31)
            begin
                j = i;
                while (j + 1 < nruns && rsym(j + 1) == a)
                    j++;
                if (rlen(j) == 31)
                begin
                    open_gap(j + 1, 1);
                    runs[j + 1] = one;
                end
                else
                    runs[j] = runs[j] + 8'd8;
            end
            else
                runs[i] = runs[i] + 8'd8;
        end
        else if (rest == 0)
        begin
            open_gap(i + 1, 1);
            runs[i + 1] = one;
        end
        else if (i + 1 < nruns && rsym(i) == rsym(i + 1))
        begin
            c = rsym(i);
            runs[i] = runs[i] - 8'(rest << 3);
            open_gap(i + 1, 1);
            runs[i + 1] = one;
            j = i + 2;
            while (j + 1 < nruns && rsym(j + 1) == c)
                j++;
            if (rlen(j) + rest > 31)
            begin
                spill = rlen(j) + rest - 31;
                runs[j] = {5'd31, 3'(c)};
                open_gap(j + 1, 1);
                runs[j + 1] = {5'(spill), 3'(c)};
            end
            else
                runs[j] = runs[j] + 8'(rest << 3);
        end
        else
        begin
            c = rsym(i);
            open_gap(i + 1, 2);
            runs[i] = runs[i] - 8'(rest << 3);
            runs[i + 1] = one;
            runs[i + 2] = {5'(rest), 3'(c)};
        end
    endfunction

    // apply one item to the model and return the result it yields
    function automatic answer_t store_step(op_t op, logic [2:0] s, int x);
        answer_t a;
        int rk, idx, off, total;
        a = '0;
        rk = 0;
        idx = 0;
        off = 0;
        total = str_len();
        if (op == OP_RANK || op == OP_INSERT)
        begin
            if (x > total || (op == OP_INSERT && s > SYM_LAST))
                a.status = ST_BAD;
            else
            begin
                rk = find_run(x, int'(s), idx, off);
                if (op == OP_INSERT)
                begin
                    if (nruns + 2 > RUN_SLOTS || total >= 8191)
                        a.status = ST_FULL;
                    else
                    begin
                        add_one(int'(s), idx, off);
                        sym_count[s]++;
                    end
                end
            end
        end
        else if (op == OP_READ)
        begin
            if (x < nruns)
            begin
                idx = x;
                a.run_byte = runs[x];
            end
            else
                a.status = ST_BAD;
        end
        a.rank = 13'(rk);
        a.run_index = 8'(idx);
        a.run_offset = 5'(off);
        a.run_total = 9'(nruns);
        a.needs_split = (nruns + 2 > limit_reg);
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // result side: random stalls, checks at each accepted item
    always @(posedge clk)
    begin
        answer_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = answer_t'(m_tdata[45:0]);
            if (pending.size() == 0)
                report_mismatch("unexpected item", 1, 0);
            else
            begin
                want = pending.pop_front();
                if (got.rank != want.rank)
                    report_mismatch("rank", got.rank, want.rank);
                if (got.run_index != want.run_index)
                    report_mismatch("run_index", got.run_index, want.run_index);
                if (got.run_offset != want.run_offset)
                    report_mismatch("run_offset", got.run_offset, want.run_offset);
                if (got.run_total != want.run_total)
                    report_mismatch("run_total", got.run_total, want.run_total);
                if (got.run_byte != want.run_byte)
                    report_mismatch("run_byte", got.run_byte, want.run_byte);
                if (got.needs_split != want.needs_split)
                    report_mismatch("needs_split", got.needs_split, want.needs_split);
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (m_tdata[47:46] != 2'b00)
                    report_mismatch("pad bits", m_tdata[47:46], 0);
            end
        end
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 5);
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // valid stays up after an accepted item until the next item or a drain
    task automatic send_item(op_t op, logic [2:0] s, int x, logic fixed, answer_t want);
        answer_t pred;
        if (!quiet && $urandom_range(0, 6) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {13'(x), s};
        do
            @(posedge clk);
        while (!s_tready);
        pred = store_step(op, s, x);
        if (fixed && pred != want)
            report_mismatch("table row vs model", int'(pred.status), int'(want.status));
        pending.push_back(fixed ? want : pred);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic set_limit(int v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= 9'(v);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        limit_reg = v;
    endtask

    function automatic answer_t ans(int rk, int idx, int off, int tot, int sp, status_t st);
        answer_t a;
        a = '0;
        a.rank = 13'(rk);
        a.run_index = 8'(idx);
        a.run_offset = 5'(off);
        a.run_total = 9'(tot);
        a.needs_split = 1'(sp);
        a.status = st;
        return a;
    endfunction

    initial
    begin
        row_t rows [$];
        row_t r;
        op_t  op;
        int   pick, x, total, n;

        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_RANK;
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        nruns = 0;
        limit_reg = 64;
        foreach (sym_count[k])
            sym_count[k] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, bad operands, then a few inserts, ranks and reads
        rows.push_back('{OP_RANK,   3'd0, 0,    1'b1, ans(0, 0, 0, 0, 0, ST_OK)});
        rows.push_back('{OP_RANK,   3'd7, 1,    1'b1, ans(0, 0, 0, 0, 0, ST_BAD)});
        rows.push_back('{OP_READ,   3'd0, 0,    1'b1, ans(0, 0, 0, 0, 0, ST_BAD)});
        rows.push_back('{OP_INSERT, 3'd6, 0,    1'b1, ans(0, 0, 0, 0, 0, ST_BAD)});
        rows.push_back('{OP_INSERT, 3'd7, 0,    1'b1, ans(0, 0, 0, 0, 0, ST_BAD)});
        rows.push_back('{OP_INSERT, 3'd0, 8191, 1'b1, ans(0, 0, 0, 0, 0, ST_BAD)});
        rows.push_back('{OP_NONE,   3'd7, 8191, 1'b1, ans(0, 0, 0, 0, 0, ST_OK)});
        rows.push_back('{OP_INSERT, 3'd2, 0,    1'b1, ans(0, 0, 0, 1, 0, ST_OK)});
        rows.push_back('{OP_INSERT, 3'd2, 1,    1'b0, '0});
        rows.push_back('{OP_INSERT, 3'd5, 0,    1'b0, '0});
        rows.push_back('{OP_INSERT, 3'd3, 2,    1'b0, '0});
        rows.push_back('{OP_INSERT, 3'd4, 4,    1'b0, '0});
        rows.push_back('{OP_INSERT, 3'd1, 5,    1'b0, '0});
        rows.push_back('{OP_INSERT, 3'd0, 1,    1'b0, '0});
        rows.push_back('{OP_RANK,   3'd2, 7,    1'b0, '0});
        rows.push_back('{OP_RANK,   3'd6, 3,    1'b0, '0});
        rows.push_back('{OP_RANK,   3'd5, 7,    1'b0, '0});
        rows.push_back('{OP_RANK,   3'd1, 8,    1'b0, '0});
        rows.push_back('{OP_READ,   3'd0, 1,    1'b0, '0});
        rows.push_back('{OP_READ,   3'd0, 255,  1'b0, '0});
        foreach (rows[k])
        begin
            r = rows[k];
            send_item(r.op, r.sym, r.pos, r.fixed, r.ans);
        end
        drain();
        set_limit(6);

        // long same-symbol streaks to fill runs of 31 and spill
        for (int k = 0; k < 70; k++)
            send_item(OP_INSERT, 3'd3, $urandom_range(0, str_len()), 1'b0, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0: set_limit(256);
                1: set_limit($urandom_range(6, 256));
                2: set_limit(511);
                default: set_limit(64);
            endcase
            n = (phase == 2) ? 300 : 120;
            if (phase == 3)
                quiet = 1'b1;
            for (int k = 0; k < n; k++)
            begin
                total = str_len();
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    op = OP_INSERT;
                else if (pick < 80)
                    op = OP_RANK;
                else if (pick < 95)
                    op = OP_READ;
                else
                    op = OP_NONE;
                if (op == OP_READ)
                    x = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
                                                  : $urandom_range(0, nruns);
                else if ($urandom_range(0, 19) == 0)
                    x = $urandom_range(0, 8191);
                else
                    x = $urandom_range(0, total);
                send_item(op, op == OP_INSERT && $urandom_range(0, 19) != 0 ?
                          3'($urandom_range(0, 5)) : 3'($urandom_range(0, 7)),
                          x, 1'b0, '0);
            end
        end
        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rle_pkg.sv
rtl/rle_run_ram.sv
rtl/rle_symbol_run_rank_insert.sv
test/tb.sv
